FILE: hw/rtl/bss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bss_pkg: shared types and codes for the bounded stack with search
// Beat layouts, action and status codes, and the per-cell command.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int DEPTH_DEF     = 8;
    localparam int WORD_BITS_DEF = 32;
    localparam int WORD_W        = 32;  // width of the word field on the port
    localparam int POS_W         = 4;
    localparam int CNT_W         = 4;
    localparam int ACT_W         = 3;
    localparam int STS_W         = 3;

    // actions
    localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REWRITE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd4;

    // status codes
    localparam logic [STS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STS_W-1:0] ST_BEYOND   = 3'd4;
    localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd5;

    // cell command kinds
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;  // every cell takes its upper neighbor
    localparam logic [1:0] CMD_WRITE = 2'd2;  // cell at idx loads the word
    localparam logic [1:0] CMD_PULL  = 2'd3;  // cells at idx and below take lower neighbor

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] word;
    } t_in;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [POS_W-1:0] found_position;
        logic [CNT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  idx;
        logic [WORD_W-1:0] word;  // data to load, or search key
    } t_cmd;

endpackage
`default_nettype wire

FILE: hw/rtl/bss_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bss_cell: one stack slot
// Holds one word, shifts with its neighbors and compares against the key.
// ----------------------------------------------------------------------------
module bss_cell #(
    parameter int INDEX  = 0,
    parameter int W      = bss_pkg::WORD_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire  bss_pkg::t_cmd  i_cmd,
    input  wire  [W-1:0]         i_prev,        // word of the cell above
    input  wire  [W-1:0]         i_next,        // word of the cell below
    input  wire                  i_valid,       // slot holds a stored word
    input  wire                  i_found_above,
    output logic [W-1:0]         o_word,
    output logic                 o_found_above,
    output logic                 o_first_hit
);

    logic [W-1:0] r_word;
    logic [W-1:0] n_word;
    logic         hit;

    always_comb begin
        n_word = r_word;
        unique case (i_cmd.kind)
            bss_pkg::CMD_PUSH: n_word = i_prev;
            bss_pkg::CMD_WRITE: begin
                if (i_cmd.idx == bss_pkg::POS_W'(INDEX)) n_word = i_cmd.word[W-1:0];
            end
            bss_pkg::CMD_PULL: begin
                if (bss_pkg::POS_W'(INDEX) >= i_cmd.idx) n_word = i_next;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign hit           = i_valid && (r_word == i_cmd.word[W-1:0]);
    assign o_first_hit   = hit && !i_found_above;
    assign o_found_above = hit || i_found_above;
    assign o_word        = r_word;

endmodule
`default_nettype wire

FILE: hw/rtl/bounded_stack_with_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stack_with_search: LIFO stack of DEPTH words with search
// The result beat is registered and appears in the cycle after start is taken.
// Throughput: one action per cycle; busy stays low, as every action
// completes in the single pass through the cell row.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; stored words are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module bounded_stack_with_search #(
    parameter int DEPTH     = bss_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bss_pkg::WORD_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire bss_pkg::t_in   i_cmd,
    output logic                busy,
    output logic                o_strobe,
    output bss_pkg::t_out       o_result
);

    // Only the low bits of the word that fit in a slot are kept or compared.
    localparam int KEEP = (WORD_BITS < bss_pkg::WORD_W) ? WORD_BITS : bss_pkg::WORD_W;

    // Cell 0 is the top of the stack (position 1); cell k is position k+1.
    logic [KEEP-1:0]          cell_word [DEPTH];
    logic [DEPTH:0]           found_chain;
    logic [DEPTH-1:0]         first_hit;

    logic [bss_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_strobe;
    bss_pkg::t_out             r_result, n_result;
    bss_pkg::t_cmd             cmd;
    logic                      accept;
    logic                      empty, full, pos_bad, pos_beyond;
    logic [bss_pkg::POS_W-1:0] hit_pos;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign empty      = (r_count == '0);
    assign full       = ({1'b0, r_count} >= (bss_pkg::CNT_W + 1)'(DEPTH));
    assign pos_bad    = (i_cmd.position == '0) ||
                        ({1'b0, i_cmd.position} > (bss_pkg::POS_W + 1)'(DEPTH));
    assign pos_beyond = (i_cmd.position > r_count);

    // Topmost hit: the found flag ripples down the cell row, so at most one
    // cell reports a first hit and its position can be OR-ed out.
    assign found_chain[0] = 1'b0;

    always_comb begin
        hit_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (first_hit[k]) hit_pos = hit_pos | bss_pkg::POS_W'(k + 1);
        end
    end

    // Decode the action into one command broadcast to every cell, plus the
    // result beat and the new count.
    always_comb begin
        cmd.kind = bss_pkg::CMD_HOLD;
        cmd.idx  = i_cmd.position - 1'b1;
        cmd.word = i_cmd.word;
        n_count  = r_count;
        n_result.status         = bss_pkg::ST_OK;
        n_result.found_position = '0;

        unique case (i_cmd.action) inside
            bss_pkg::ACT_PUSH: begin
                if (full) begin
                    n_result.status = bss_pkg::ST_FULL;
                end else begin
                    cmd.kind = bss_pkg::CMD_PUSH;
                    n_count  = r_count + 1'b1;
                end
            end
            bss_pkg::ACT_POP: begin
                if (empty) begin
                    n_result.status = bss_pkg::ST_EMPTY;
                end else begin
                    cmd.kind = bss_pkg::CMD_PULL;
                    cmd.idx  = '0;
                    n_count  = r_count - 1'b1;
                end
            end
            bss_pkg::ACT_FIND: begin
                if (empty) begin
                    n_result.status = bss_pkg::ST_EMPTY;
                end else if (found_chain[DEPTH]) begin
                    n_result.found_position = hit_pos;
                end else begin
                    n_result.status = bss_pkg::ST_NOTFOUND;
                end
            end
            bss_pkg::ACT_REWRITE, bss_pkg::ACT_REMOVE: begin
                if (empty) begin
                    n_result.status = bss_pkg::ST_EMPTY;
                end else if (pos_bad) begin
                    n_result.status = bss_pkg::ST_RANGE;
                end else if (pos_beyond) begin
                    n_result.status = bss_pkg::ST_BEYOND;
                end else if (i_cmd.action == bss_pkg::ACT_REWRITE) begin
                    cmd.kind = bss_pkg::CMD_WRITE;
                end else begin
                    // close the gap: words below the removed one move up
                    cmd.kind = bss_pkg::CMD_PULL;
                    n_count  = r_count - 1'b1;
                end
            end
            default: ;  // unused codes: no change, ok status
        endcase

        if (!accept) cmd.kind = bss_pkg::CMD_HOLD;
        n_result.entry_count = n_count;
    end

    // Cell row
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [KEEP-1:0] prev_w, next_w;
        logic            valid;

        if (k == 0) begin : g_top
            assign prev_w = i_cmd.word[KEEP-1:0];
        end else begin : g_mid
            assign prev_w = cell_word[k-1];
        end

        if (k == DEPTH - 1) begin : g_bottom
            assign next_w = cell_word[k];
        end else begin : g_inner
            assign next_w = cell_word[k+1];
        end

        assign valid = ((bss_pkg::CNT_W + 1)'(k) < {1'b0, r_count});

        bss_cell #(
            .INDEX (k),
            .W     (KEEP)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_prev        (prev_w),
            .i_next        (next_w),
            .i_valid       (valid),
            .i_found_above (found_chain[k]),
            .o_word        (cell_word[k]),
            .o_found_above (found_chain[k+1]),
            .o_first_hit   (first_hit[k])
        );
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) r_count <= n_count;
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (accept) r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire
